// ----- sv/crcfr_pkg.sv -----
// package for the crc8 command frame receiver
// holds item and result types, status codes, register indexes and the crc update
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package crcfr_pkg;

  localparam int BYTE_W = 8;
  localparam int SIZE_W = 7;
  localparam int SLOT_W = 3;
  localparam int IDX_W = 3;
  localparam int SIZE_REGS = 6;
  localparam int MIN_BODY = 3;
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CMD_BASE_RESET = 8'd11;
  localparam logic [7:0] COUNT_MAX = 8'd255;

  localparam logic [IDX_W-1:0] REG_CMD_BASE = 3'd0;
  localparam logic [IDX_W-1:0] REG_SIZE0 = 3'd1;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_SHORT = 3'd1,
    ST_CRC = 3'd2,
    ST_CMD = 3'd3,
    ST_LEN = 3'd4,
    ST_OVF = 3'd5
  } status_t;

  typedef struct packed {
    logic kind;
    logic [7:0] rx_byte;
    logic frame_end;
    logic [2:0] read_slot;
    logic [5:0] read_offset;
  } item_t;

  typedef struct packed {
    status_t frame_status;
    logic [7:0] frame_command;
    logic [7:0] read_value;
  } result_t;

  typedef struct packed {
    logic clr_step;
    logic byte_en;
    logic fin_en;
    logic rd_issue;
    logic rd_load;
    logic copy_step;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic fin_copy;
    logic clr_last;
    logic copy_last;
  } dp_status_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- sv/crcfr_ctrl.sv -----
// controller for the crc8 command frame receiver
// sequences store clearing, frame bytes, reads and payload copies
// depends on crcfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module crcfr_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    item_valid,
  input  wire                    item_kind,
  input  wire                    item_frame_end,
  output logic                   item_ready,
  input  crcfr_pkg::dp_status_t  status,
  output crcfr_pkg::dp_cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_COPY  = 5'b01000,
    S_DRAIN = 5'b10000
  } state_t;

  state_t state, state_next;
  logic take;

  assign item_ready = (state == S_IDLE) && status.out_free;
  assign take = item_valid && item_ready;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (take) begin
          if (item_kind) begin
            cmd.rd_issue = 1'b1;
            state_next = S_READ;
          end else if (item_frame_end) begin
            cmd.fin_en = 1'b1;
            if (status.fin_copy) begin
              state_next = S_COPY;
            end
          end else begin
            cmd.byte_en = 1'b1;
          end
        end
      end
      S_READ: begin
        if (status.out_free) begin
          cmd.rd_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (status.copy_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/crcfr_dp.sv -----
// datapath for the crc8 command frame receiver
// frame registers, crc, staging buffer, settings store, config and result register
// depends on crcfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module crcfr_dp #(
  parameter int MAX_PAYLOAD = 64,
  parameter int NUM_SLOTS = 6
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire [crcfr_pkg::IDX_W-1:0]         cfg_index,
  input  wire [crcfr_pkg::BYTE_W-1:0]        cfg_data,
  input  crcfr_pkg::item_t                   item,
  input  crcfr_pkg::dp_cmd_t                 cmd,
  output crcfr_pkg::dp_status_t              status,
  output logic                               result_valid,
  input  wire                                result_ready,
  output crcfr_pkg::result_t                 result
);

  localparam int DEPTH = NUM_SLOTS * MAX_PAYLOAD;
  localparam int OFF_W = $clog2(MAX_PAYLOAD);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [7:0] MAX_B = 8'(MAX_PAYLOAD);
  localparam logic [7:0] SLOTS_B = 8'(NUM_SLOTS);

  logic [7:0] cmd_base;
  logic [crcfr_pkg::SIZE_W-1:0] slot_size [crcfr_pkg::SIZE_REGS];

  logic [7:0] crc;
  logic [7:0] bcount;
  logic [7:0] cmd_q;
  logic [7:0] len_q;
  logic ovf;

  logic [7:0] stage_mem [MAX_PAYLOAD];
  logic [7:0] stage_rdata;
  logic [7:0] store_mem [DEPTH];
  logic [7:0] store_rdata;

  logic [ADDR_W-1:0] clr_cnt;
  logic [ADDR_W-1:0] copy_base;
  logic [7:0] copy_len;
  logic [OFF_W-1:0] cp_idx;
  logic [OFF_W-1:0] wr_off;
  logic wr_pend;
  logic rd_inrange;

  // frame byte bookkeeping
  logic [7:0] idx;
  logic stage_ok;
  assign idx = bcount - 8'd2;
  assign stage_ok = (bcount >= 8'd2) && (bcount != crcfr_pkg::COUNT_MAX) && (idx < MAX_B);

  // frame end checks
  logic [7:0] slot_diff;
  logic [crcfr_pkg::SLOT_W-1:0] slot;
  logic cmd_bad;
  logic [7:0] size_sel;
  crcfr_pkg::status_t fin_status;

  assign slot_diff = cmd_q - cmd_base;
  assign slot = slot_diff[crcfr_pkg::SLOT_W-1:0];
  assign cmd_bad = (cmd_q < cmd_base) || (slot_diff >= SLOTS_B);

  always_comb begin
    size_sel = 8'd0;
    if (32'(slot) < crcfr_pkg::SIZE_REGS) begin
      size_sel = {1'b0, slot_size[slot]};
    end
    if (bcount < 8'(crcfr_pkg::MIN_BODY)) begin
      fin_status = crcfr_pkg::ST_SHORT;
    end else if (crc != item.rx_byte) begin
      fin_status = crcfr_pkg::ST_CRC;
    end else if (ovf) begin
      fin_status = crcfr_pkg::ST_OVF;
    end else if (cmd_bad) begin
      fin_status = crcfr_pkg::ST_CMD;
    end else if ((len_q != size_sel) || (idx != len_q)) begin
      fin_status = crcfr_pkg::ST_LEN;
    end else begin
      fin_status = crcfr_pkg::ST_OK;
    end
  end

  // read address
  logic rd_ok;
  logic [ADDR_W-1:0] rd_addr;
  assign rd_ok = (8'(item.read_slot) < SLOTS_B) && (8'(item.read_offset) < MAX_B);
  assign rd_addr = rd_ok ? (ADDR_W'(item.read_slot) * ADDR_W'(MAX_PAYLOAD)
                            + ADDR_W'(item.read_offset)) : '0;

  assign status.out_free = !result_valid || result_ready;
  assign status.fin_copy = (fin_status == crcfr_pkg::ST_OK) && (len_q != 8'd0);
  assign status.clr_last = (clr_cnt == ADDR_W'(DEPTH - 1));
  assign status.copy_last = (8'(cp_idx) == copy_len - 8'd1);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_base <= crcfr_pkg::CMD_BASE_RESET;
      for (int i = 0; i < crcfr_pkg::SIZE_REGS; i++) begin
        slot_size[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == crcfr_pkg::REG_CMD_BASE) begin
        cmd_base <= cfg_data;
      end
      for (int i = 0; i < crcfr_pkg::SIZE_REGS; i++) begin
        if (cfg_index == crcfr_pkg::REG_SIZE0 + crcfr_pkg::IDX_W'(i)) begin
          slot_size[i] <= cfg_data[crcfr_pkg::SIZE_W-1:0];
        end
      end
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst || cmd.fin_en) begin
      crc <= '0;
      bcount <= '0;
      cmd_q <= '0;
      len_q <= '0;
      ovf <= 1'b0;
    end else if (cmd.byte_en) begin
      crc <= crcfr_pkg::crc8_update(crc, item.rx_byte);
      if (bcount == 8'd0) begin
        cmd_q <= item.rx_byte;
      end else if (bcount == 8'd1) begin
        len_q <= item.rx_byte;
      end else if (!stage_ok) begin
        ovf <= 1'b1;
      end
      if (bcount != crcfr_pkg::COUNT_MAX) begin
        bcount <= bcount + 8'd1;
      end
    end
  end

  // staging buffer
  always_ff @(posedge clk) begin
    if (cmd.byte_en && stage_ok) begin
      stage_mem[idx[OFF_W-1:0]] <= item.rx_byte;
    end
    if (cmd.copy_step) begin
      stage_rdata <= stage_mem[cp_idx];
    end
  end

  // copy sequencing and clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      wr_pend <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      wr_pend <= cmd.copy_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_en) begin
      copy_base <= ADDR_W'(slot) * ADDR_W'(MAX_PAYLOAD);
      copy_len <= len_q;
      cp_idx <= '0;
    end else if (cmd.copy_step) begin
      cp_idx <= cp_idx + OFF_W'(1);
    end
    if (cmd.copy_step) begin
      wr_off <= cp_idx;
    end
    if (cmd.rd_issue) begin
      rd_inrange <= rd_ok;
    end
  end

  // settings store
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      store_mem[clr_cnt] <= 8'd0;
    end else if (wr_pend) begin
      store_mem[copy_base + ADDR_W'(wr_off)] <= stage_rdata;
    end
    if (cmd.rd_issue) begin
      store_rdata <= store_mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.fin_en || cmd.rd_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_en) begin
      result.frame_status <= fin_status;
      result.frame_command <= cmd_q;
      result.read_value <= 8'd0;
    end else if (cmd.rd_load) begin
      result.frame_status <= crcfr_pkg::ST_OK;
      result.frame_command <= 8'd0;
      result.read_value <= rd_inrange ? store_rdata : 8'd0;
    end
  end

endmodule

`default_nettype wire

// ----- sv/crc8_command_frame_receiver_unit.sv -----
// crc8 command frame receiver: frame bytes update the crc and frame registers;
// a frame end that passes with nonzero length starts a payload copy into the store,
// a read goes through the registered store read port
// results sit in an output register; the input waits while a held result is not taken
// reset clears frame state and config; a clearing pass over NUM_SLOTS * MAX_PAYLOAD
// store entries then zeroes the settings store before the first item is accepted
`timescale 1ns / 1ps
`default_nettype none

module crc8_command_frame_receiver_unit #(
  parameter int MAX_PAYLOAD = 64,
  parameter int NUM_SLOTS = 6
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire [crcfr_pkg::IDX_W-1:0]   cfg_index,
  input  wire [crcfr_pkg::BYTE_W-1:0]  cfg_data,
  input  wire                          item_valid,
  output logic                         item_ready,
  input  crcfr_pkg::item_t             item,
  output logic                         result_valid,
  input  wire                          result_ready,
  output crcfr_pkg::result_t           result
);

  crcfr_pkg::dp_cmd_t cmd;
  crcfr_pkg::dp_status_t status;

  crcfr_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_kind      (item.kind),
    .item_frame_end (item.frame_end),
    .item_ready     (item_ready),
    .status         (status),
    .cmd            (cmd)
  );

  crcfr_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .NUM_SLOTS   (NUM_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// testbench for crc8_command_frame_receiver_unit: directed and random frames and reads
// results are checked against an in-bench model of the crc check, slot rules and store
// depends on crcfr_pkg and the receiver rtl
`timescale 1ns / 1ps

module tb;

  localparam int MAX_PAYLOAD = 64;
  localparam int NUM_SLOTS = 6;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_AFTER = 80;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 150;
  localparam int ITEM_W = $bits(crcfr_pkg::item_t);

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [crcfr_pkg::IDX_W-1:0] cfg_index = '0;
  logic [crcfr_pkg::BYTE_W-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_ready;
  crcfr_pkg::item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  crcfr_pkg::result_t result;

  // model of the frame state, configuration and settings store
  logic [7:0] crc_acc;
  logic [7:0] frame_bytes;
  logic [7:0] held_cmd;
  logic [7:0] held_len;
  bit frame_ovf;
  logic [7:0] staging [MAX_PAYLOAD];
  logic [7:0] settings_mirror [NUM_SLOTS*MAX_PAYLOAD];
  logic [7:0] cmd_base;
  logic [6:0] slot_size [NUM_SLOTS];
  logic [6:0] plan_sizes [NUM_SLOTS];

  crcfr_pkg::item_t pending_items [$];
  crcfr_pkg::result_t expected_results [$];

  int items_queued = 0;
  int items_in = 0;
  int results_seen = 0;
  int reads_done = 0;
  int error_count = 0;
  int idle_cycles = 0;
  int frame_outcomes [6] = '{default: 0};
  logic in_took = 1'b0;
  int gap_left = 0;
  int burst_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic [7:0] rx_tick = '0;

  crc8_command_frame_receiver_unit #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .NUM_SLOTS(NUM_SLOTS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    repeat (8) r = (r << 1) ^ (r[7] ? crcfr_pkg::CRC_POLY : 8'h00);
    return r;
  endfunction

  // advances the model by one item; returns 1 when the item yields a result
  function automatic bit receiver_step(input crcfr_pkg::item_t it,
                                       output crcfr_pkg::result_t r);
    crcfr_pkg::status_t st;
    int slot;
    int plen;
    int idx;
    int i;
    r = '0;
    if (it.kind) begin
      reads_done++;
      if (it.read_slot < NUM_SLOTS) begin
        r.read_value = settings_mirror[it.read_slot * MAX_PAYLOAD + it.read_offset];
      end
      return 1'b1;
    end
    if (it.frame_end) begin
      slot = int'(held_cmd) - int'(cmd_base);
      plen = int'(frame_bytes) - 2;
      if (frame_bytes < crcfr_pkg::MIN_BODY) begin
        st = crcfr_pkg::ST_SHORT;
      end else if (crc_acc != it.rx_byte) begin
        st = crcfr_pkg::ST_CRC;
      end else if (frame_ovf) begin
        st = crcfr_pkg::ST_OVF;
      end else if (slot < 0 || slot >= NUM_SLOTS) begin
        st = crcfr_pkg::ST_CMD;
      end else if (held_len != slot_size[slot] || plen != held_len) begin
        st = crcfr_pkg::ST_LEN;
      end else begin
        st = crcfr_pkg::ST_OK;
        for (i = 0; i < plen; i++) begin
          settings_mirror[slot * MAX_PAYLOAD + i] = staging[i];
        end
      end
      r.frame_status = st;
      r.frame_command = held_cmd;
      frame_outcomes[int'(st)]++;
      crc_acc = '0;
      frame_bytes = '0;
      held_cmd = '0;
      held_len = '0;
      frame_ovf = 1'b0;
      return 1'b1;
    end
    crc_acc = crc8_next(crc_acc, it.rx_byte);
    if (frame_bytes == 8'd0) begin
      held_cmd = it.rx_byte;
    end else if (frame_bytes == 8'd1) begin
      held_len = it.rx_byte;
    end else begin
      idx = int'(frame_bytes) - 2;
      if (frame_bytes == crcfr_pkg::COUNT_MAX || idx >= MAX_PAYLOAD) begin
        frame_ovf = 1'b1;
      end else begin
        staging[idx] = it.rx_byte;
      end
    end
    if (frame_bytes != crcfr_pkg::COUNT_MAX) begin
      frame_bytes++;
    end
    return 1'b0;
  endfunction

  task automatic queue_item(input crcfr_pkg::item_t it);
    pending_items.push_back(it);
    items_queued++;
  endtask

  // body_len counts the bytes before the crc byte: command, length, payload
  task automatic add_frame(input logic [7:0] cmd, input logic [7:0] decl,
                           input int body_len, input bit bad_crc);
    crcfr_pkg::item_t it;
    logic [7:0] crc;
    logic [7:0] b;
    int i;
    crc = '0;
    for (i = 0; i < body_len; i++) begin
      b = (i == 0) ? cmd : (i == 1) ? decl : 8'($urandom_range(0, 255));
      crc = crc8_next(crc, b);
      it.kind = 1'b0;
      it.rx_byte = b;
      it.frame_end = 1'b0;
      it.read_slot = 3'($urandom_range(0, 7));
      it.read_offset = 6'($urandom_range(0, 63));
      queue_item(it);
    end
    if (bad_crc) begin
      crc ^= 8'($urandom_range(1, 255));
    end
    it.kind = 1'b0;
    it.rx_byte = crc;
    it.frame_end = 1'b1;
    it.read_slot = 3'($urandom_range(0, 7));
    it.read_offset = 6'($urandom_range(0, 63));
    queue_item(it);
  endtask

  task automatic add_read(input int slot, input int offset);
    crcfr_pkg::item_t it;
    it.kind = 1'b1;
    it.rx_byte = 8'($urandom_range(0, 255));
    it.frame_end = 1'($urandom_range(0, 1));
    it.read_slot = 3'(slot);
    it.read_offset = 6'(offset);
    queue_item(it);
  endtask

  task automatic apply_settings(input logic [7:0] base);
    int s;
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= crcfr_pkg::REG_CMD_BASE;
    cfg_data <= base;
    cmd_base = base;
    for (s = 0; s < NUM_SLOTS; s++) begin
      @(negedge clk);
      cfg_index <= crcfr_pkg::REG_SIZE0 + crcfr_pkg::IDX_W'(s);
      cfg_data <= crcfr_pkg::BYTE_W'(plan_sizes[s]);
      slot_size[s] = plan_sizes[s];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || item_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int n_items);
    int goal;
    int r;
    int slot;
    int body;
    logic [7:0] cmd;
    logic [7:0] decl;
    logic [ITEM_W-1:0] raw;
    goal = items_queued + n_items;
    while (items_queued < goal) begin
      r = $urandom_range(0, 99);
      slot = $urandom_range(0, NUM_SLOTS - 1);
      cmd = cmd_base + 8'(slot);
      decl = 8'(slot_size[slot]);
      if (r < 45) begin
        add_frame(cmd, decl, decl + 2, 1'b0);
      end else if (r < 50) begin
        add_frame(cmd, decl, decl + 2, 1'b1);
      end else if (r < 55) begin
        do cmd = 8'($urandom_range(0, 255));
        while (cmd >= cmd_base && int'(cmd - cmd_base) < NUM_SLOTS);
        add_frame(cmd, decl, decl + 2, 1'b0);
      end else if (r < 60) begin
        do decl = 8'($urandom_range(0, 10));
        while (decl == 8'(slot_size[slot]));
        add_frame(cmd, decl, decl + 2, 1'b0);
      end else if (r < 64) begin
        body = (decl == 0 || $urandom_range(0, 1)) ? decl + 3 : decl + 1;
        add_frame(cmd, decl, body, 1'b0);
      end else if (r < 66) begin
        add_frame(cmd, decl, MAX_PAYLOAD + 2 + $urandom_range(1, 4), 1'b0);
      end else if (r < 68) begin
        add_frame(cmd, decl, $urandom_range(0, 2), 1'b0);
      end else if (r < 85) begin
        add_read($urandom_range(0, 7),
                 $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 63));
      end else begin
        raw = ITEM_W'($urandom);
        queue_item(crcfr_pkg::item_t'(raw));
      end
    end
    // close any frame left open by noise
    add_frame(8'd0, 8'd0, 0, $urandom_range(0, 1));
  endtask

  // driver: bursts of transactions separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || in_took) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        item_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        item <= pending_items.pop_front();
        item_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // result side: one long hold-off, otherwise a rotating stall pattern
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 8'd1;
      case (rx_tick[7:6])
        2'd0: result_ready <= 1'b1;
        2'd1: result_ready <= ($urandom_range(0, 1) == 0);
        2'd2: result_ready <= (rx_tick[2:0] < 3'd5);
        default: result_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // monitor: predict on accepted input, compare on accepted output
  always @(posedge clk) begin : monitor
    crcfr_pkg::result_t pred;
    crcfr_pkg::result_t want;
    if (rst) begin
      in_took <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_took <= item_valid && item_ready;
      if (item_valid && item_ready) begin
        items_in++;
        if (receiver_step(item, pred)) begin
          expected_results.push_back(pred);
        end
      end
      if (result_valid && result_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d command %0d value %0d",
                 result.frame_status, result.frame_command, result.read_value);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (result.frame_status !== want.frame_status) begin
            $error("frame_status: expected %0d, got %0d", want.frame_status,
                   result.frame_status);
            error_count++;
          end
          if (result.frame_command !== want.frame_command) begin
            $error("frame_command: expected %0d, got %0d", want.frame_command,
                   result.frame_command);
            error_count++;
          end
          if (result.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value,
                   result.read_value);
            error_count++;
          end
        end
      end
      if ((item_valid && item_ready) || (result_valid && result_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("timeout after %0d cycles without a transaction", WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int p;
    int s;
    crc_acc = '0;
    frame_bytes = '0;
    held_cmd = '0;
    held_len = '0;
    frame_ovf = 1'b0;
    cmd_base = crcfr_pkg::CMD_BASE_RESET;
    foreach (staging[i]) staging[i] = '0;
    foreach (settings_mirror[i]) settings_mirror[i] = '0;
    foreach (slot_size[i]) slot_size[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: empty store, short frames, zero sizes
    add_read(0, 0);
    add_read(7, 63);
    add_frame(8'h00, 8'h00, 0, 1'b0);
    add_frame(8'hff, 8'h00, 1, 1'b0);
    add_frame(8'd11, 8'h00, 2, 1'b0);
    add_frame(8'd11, 8'h00, 3, 1'b0);
    drain();

    plan_sizes = '{7'd1, 7'd64, 7'd2, 7'd3, 7'd0, 7'd4};
    apply_settings(8'd0);
    add_frame(8'd0, 8'd1, 3, 1'b0);
    add_read(0, 0);
    add_frame(8'd2, 8'd2, 4, 1'b1);
    add_frame(8'd6, 8'd1, 3, 1'b0);
    add_frame(8'd2, 8'd3, 5, 1'b0);
    add_frame(8'd3, 8'd3, 4, 1'b0);
    add_read(5, 63);
    random_phase(PHASE_ITEMS);
    drain();

    plan_sizes = '{7'd64, 7'd1, 7'd0, 7'd2, 7'd5, 7'd3};
    apply_settings(8'd250);
    random_phase(PHASE_ITEMS);

    for (p = 0; p < 3; p++) begin
      drain();
      for (s = 0; s < NUM_SLOTS; s++) begin
        if ($urandom_range(0, 7) == 0) begin
          plan_sizes[s] = $urandom_range(0, 1) ? 7'd64 : 7'($urandom_range(0, 64));
        end else begin
          plan_sizes[s] = 7'($urandom_range(1, 8));
        end
      end
      apply_settings(8'($urandom_range(0, 250)));
      random_phase(PHASE_ITEMS);
    end
    // frame long enough to saturate the byte count
    add_frame(cmd_base, 8'(slot_size[0]), 260, 1'b0);
    drain();

    $display("covered %0d input transactions and %0d results, %0d of them reads",
             items_in, results_seen, reads_done);
    $display("frame outcomes ok/short/crc/cmd/len/ovf: %0d/%0d/%0d/%0d/%0d/%0d",
             frame_outcomes[0], frame_outcomes[1], frame_outcomes[2],
             frame_outcomes[3], frame_outcomes[4], frame_outcomes[5]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
